@@ hw/rtl/abrp_pkg.sv @@
package abrp_pkg;

  localparam int NUM_BUFFERS_DEF    = 4;
  localparam int BUFFER_SAMPLES_DEF = 2048;

  localparam int ACT_W    = 2;
  localparam int INDEX_W  = 11;
  localparam int SAMPLE_W = 8;
  localparam int COUNT_W  = 12;
  localparam int GAIN_W   = 4;
  localparam int DUTY_W   = 12;

  localparam logic [GAIN_W-1:0]   GAIN_RESET = 4'd8;
  localparam logic [SAMPLE_W-1:0] MIDSCALE   = 8'd128;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE  = 2'd0,
    ACT_COMMIT = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_ACK    = 2'd3
  } action_t;

endpackage

@@ hw/rtl/abrp_ram.sv @@
module abrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/abrp_ctrl.sv @@
module abrp_ctrl
  import abrp_pkg::*;
#(
  parameter int NUM_BUFFERS    = NUM_BUFFERS_DEF,
  parameter int BUFFER_SAMPLES = BUFFER_SAMPLES_DEF,
  localparam int ADDR_W        = $clog2(NUM_BUFFERS * BUFFER_SAMPLES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [GAIN_W-1:0]   gain,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACT_W-1:0]    action,
  input  logic [INDEX_W-1:0]  sample_index,
  input  logic [SAMPLE_W-1:0] sample_value,
  input  logic [COUNT_W-1:0]  sample_count,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DUTY_W-1:0]   duty,
  output logic                duty_valid,
  output logic                accepted,
  output logic                underrun,
  output logic                ram_we,
  output logic [ADDR_W-1:0]   ram_waddr,
  output logic [SAMPLE_W-1:0] ram_wdata,
  output logic                ram_re,
  output logic [ADDR_W-1:0]   ram_raddr,
  input  logic [SAMPLE_W-1:0] ram_rdata
);

  localparam int SLOT_W = $clog2(NUM_BUFFERS);
  localparam int POS_W  = $clog2(BUFFER_SAMPLES);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t              st;
  action_t             act_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic                wr_ok_q;

  logic [SLOT_W-1:0]   write_slot, write_slot_next;
  logic [SLOT_W-1:0]   read_slot, read_slot_next;
  logic [COUNT_W-1:0]  samples_left, samples_left_next;
  logic [POS_W-1:0]    read_position, read_position_next;
  logic [SAMPLE_W-1:0] last_sample, last_sample_next;
  logic                underrun_flag, underrun_flag_next;
  logic                playing, playing_next;
  logic [COUNT_W-1:0]  counts [NUM_BUFFERS];

  logic [SLOT_W-1:0]   nxt_slot, rs_next;
  logic                ring_full, idx_ok, in_acc, exec_done;
  logic [COUNT_W-1:0]  sat_cnt;
  logic                cnt_we;
  logic                flag_upd, valid_res, acc_res;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    if (32'(s) == NUM_BUFFERS - 1) begin
      return '0;
    end
    return s + SLOT_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
    return ADDR_W'(s) * ADDR_W'(BUFFER_SAMPLES);
  endfunction

  assign nxt_slot  = next_slot(write_slot);
  assign rs_next   = next_slot(read_slot);
  assign ring_full = (nxt_slot == read_slot);
  assign idx_ok    = (32'(sample_index) < BUFFER_SAMPLES);
  assign in_stall  = (st != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign exec_done = (st == S_EXEC) && (!out_valid || !out_stall);

  assign ram_we    = in_acc && (action_t'(action) == ACT_WRITE) && idx_ok && !ring_full;
  assign ram_waddr = slot_base(nxt_slot) + ADDR_W'(sample_index);
  assign ram_wdata = sample_value;
  assign ram_re    = in_acc && (action_t'(action) == ACT_TICK);
  assign ram_raddr = (samples_left == '0) ? slot_base(rs_next)
                                          : slot_base(read_slot) + ADDR_W'(read_position);

  assign sat_cnt = (32'(cnt_q) > BUFFER_SAMPLES) ? COUNT_W'(BUFFER_SAMPLES) : cnt_q;

  always_comb begin
    write_slot_next    = write_slot;
    read_slot_next     = read_slot;
    samples_left_next  = samples_left;
    read_position_next = read_position;
    last_sample_next   = last_sample;
    playing_next       = playing;
    flag_upd           = underrun_flag;
    valid_res          = 1'b0;
    acc_res            = 1'b0;
    cnt_we             = 1'b0;
    unique case (act_q)
      ACT_WRITE: begin
        acc_res = wr_ok_q;
      end
      ACT_COMMIT: begin
        if (!ring_full) begin
          cnt_we          = 1'b1;
          write_slot_next = nxt_slot;
          acc_res         = 1'b1;
          if (!playing) begin
            playing_next       = 1'b1;
            read_slot_next     = nxt_slot;
            samples_left_next  = sat_cnt;
            read_position_next = '0;
          end
        end
      end
      ACT_TICK: begin
        if (playing) begin
          valid_res = 1'b1;
          if (samples_left == '0) begin
            if (read_slot == write_slot) begin
              flag_upd = 1'b1;
            end else begin
              read_slot_next     = rs_next;
              samples_left_next  = counts[rs_next];
              read_position_next = '0;
              if (counts[rs_next] != '0) begin
                last_sample_next = ram_rdata;
              end
            end
          end else begin
            last_sample_next   = ram_rdata;
            read_position_next = read_position + POS_W'(1);
            samples_left_next  = samples_left - COUNT_W'(1);
          end
        end
      end
      ACT_ACK: begin
      end
      default: begin
      end
    endcase
    underrun_flag_next = (act_q == ACT_ACK) ? 1'b0 : flag_upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      out_valid     <= 1'b0;
      write_slot    <= '0;
      read_slot     <= '0;
      samples_left  <= '0;
      read_position <= '0;
      last_sample   <= MIDSCALE;
      underrun_flag <= 1'b1;
      playing       <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !exec_done) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            act_q   <= action_t'(action);
            cnt_q   <= sample_count;
            wr_ok_q <= idx_ok && !ring_full;
            st      <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_done) begin
            write_slot    <= write_slot_next;
            read_slot     <= read_slot_next;
            samples_left  <= samples_left_next;
            read_position <= read_position_next;
            last_sample   <= last_sample_next;
            underrun_flag <= underrun_flag_next;
            playing       <= playing_next;
            duty          <= valid_res ? DUTY_W'(last_sample_next * gain) : '0;
            duty_valid    <= valid_res;
            accepted      <= acc_res;
            underrun      <= flag_upd;
            out_valid     <= 1'b1;
            st            <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done && cnt_we) begin
      counts[nxt_slot] <= sat_cnt;
    end
  end

  a_idle_ring: assert property (@(posedge clk) disable iff (rst)
    !playing |-> (read_slot == write_slot && samples_left == '0))
    else $error("ring pointers moved before playback started");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(read_position) + 32'(samples_left)) <= BUFFER_SAMPLES)
    else $error("read position and remaining count exceed the buffer");

  a_duty_playing: assert property (@(posedge clk) disable iff (rst)
    (out_valid && duty_valid) |-> playing)
    else $error("duty value produced while not playing");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(duty_valid && accepted))
    else $error("result marks both a duty value and an accepted write");

endmodule

@@ hw/rtl/audio_buffer_ring_pwm_player.sv @@
// Ring-of-buffers PWM audio player.
// Input channel (in_valid / in_stall) carries one action per transaction:
// write sample, commit buffer, sample tick or acknowledge underrun. Every
// input transaction produces exactly one result transaction on the output
// channel (out_valid / out_stall) with duty, duty_valid, accepted and
// underrun. A transaction is taken on a clock edge where valid is high and
// stall is low.
// The input is registered into the execute state; the result is written to
// the output register on return to idle, and no new input is taken between.
// The sample memory is read at acceptance and used in the execute state. If
// the receiver stalls, the result is held in the output register, one more
// input transaction is taken, and the block then keeps in_stall high until
// the held result leaves and the next one can be written.
// The gain register is written through cfg_valid / cfg_ready / cfg_data;
// cfg_ready is always high. Reset (rst, synchronous) empties the ring, stops
// playback, sets the held sample to midscale, raises the underrun flag and
// sets gain to 8. The sample memory is not cleared and needs no pass.
module audio_buffer_ring_pwm_player
  import abrp_pkg::*;
#(
  parameter int NUM_BUFFERS    = NUM_BUFFERS_DEF,
  parameter int BUFFER_SAMPLES = BUFFER_SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [GAIN_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACT_W-1:0]    action,
  input  logic [INDEX_W-1:0]  sample_index,
  input  logic [SAMPLE_W-1:0] sample_value,
  input  logic [COUNT_W-1:0]  sample_count,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DUTY_W-1:0]   duty,
  output logic                duty_valid,
  output logic                accepted,
  output logic                underrun
);

  localparam int DEPTH  = NUM_BUFFERS * BUFFER_SAMPLES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [GAIN_W-1:0]   gain;
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain <= cfg_data;
    end
  end

  abrp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  abrp_ctrl #(
    .NUM_BUFFERS    (NUM_BUFFERS),
    .BUFFER_SAMPLES (BUFFER_SAMPLES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .gain         (gain),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .sample_count (sample_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .duty         (duty),
    .duty_valid   (duty_valid),
    .accepted     (accepted),
    .underrun     (underrun),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

endmodule

@@ verif/audio_buffer_ring_pwm_player_tb.sv @@
module audio_buffer_ring_pwm_player_tb
  import abrp_pkg::*;
();

  localparam int NUM_BUF     = NUM_BUFFERS_DEF;
  localparam int BUF_LEN     = BUFFER_SAMPLES_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int IDLE_PCT    = 35;
  localparam int FULL_PLAY   = 40;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              duty_valid;
    logic              accepted;
    logic              underrun;
  } player_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [GAIN_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ACT_W-1:0]    action = '0;
  logic [INDEX_W-1:0]  sample_index = '0;
  logic [SAMPLE_W-1:0] sample_value = '0;
  logic [COUNT_W-1:0]  sample_count = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DUTY_W-1:0]   duty;
  logic                duty_valid;
  logic                accepted;
  logic                underrun;

  // Shadow copy of the player state, advanced once per accepted transaction.
  logic [SAMPLE_W-1:0] pcm_mem [NUM_BUF*BUF_LEN];
  bit                  pcm_written [NUM_BUF*BUF_LEN];
  logic [COUNT_W-1:0]  slot_len [NUM_BUF];
  int                  fill_slot = 0;
  int                  play_slot = 0;
  logic [COUNT_W-1:0]  remaining = '0;
  logic [INDEX_W-1:0]  play_pos = '0;
  logic [SAMPLE_W-1:0] held_sample = MIDSCALE;
  logic                starved = 1'b1;
  logic                running = 1'b0;
  logic [GAIN_W-1:0]   gain_reg = GAIN_RESET;

  player_result_t due_results[$];

  bit steady = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int n_items = 0;
  int n_counted = 0;
  int n_ticks = 0;
  int n_refused = 0;
  int n_results = 0;
  int n_gains = 0;

  audio_buffer_ring_pwm_player uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .sample_index(sample_index),
    .sample_value(sample_value),
    .sample_count(sample_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .duty(duty),
    .duty_valid(duty_valid),
    .accepted(accepted),
    .underrun(underrun)
  );

  always #5 clk = ~clk;

  function automatic int next_fill();
    return (fill_slot + 1) % NUM_BUF;
  endfunction

  function automatic bit ring_full();
    return next_fill() == play_slot;
  endfunction

  function automatic int written_prefix(int slot);
    int n;
    n = 0;
    while (n < BUF_LEN && pcm_written[slot*BUF_LEN + n]) n++;
    return n;
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    return COUNT_W'($urandom_range(written_prefix(next_fill())));
  endfunction

  function automatic player_result_t advance_player(action_t act, logic [INDEX_W-1:0] idx,
                                                    logic [SAMPLE_W-1:0] val,
                                                    logic [COUNT_W-1:0] cnt);
    player_result_t r;
    int nxt;
    r = '0;
    nxt = next_fill();
    case (act)
      ACT_WRITE: begin
        if (nxt != play_slot && idx < BUF_LEN) begin
          pcm_mem[nxt*BUF_LEN + idx] = val;
          pcm_written[nxt*BUF_LEN + idx] = 1'b1;
          r.accepted = 1'b1;
        end
      end
      ACT_COMMIT: begin
        if (nxt != play_slot) begin
          slot_len[nxt] = (cnt > BUF_LEN) ? COUNT_W'(BUF_LEN) : cnt;
          fill_slot = nxt;
          r.accepted = 1'b1;
          if (!running) begin
            running = 1'b1;
            play_slot = nxt;
            remaining = slot_len[nxt];
            play_pos = '0;
          end
        end
      end
      ACT_TICK: begin
        if (running) begin
          r.duty_valid = 1'b1;
          if (remaining == 0) begin
            if (play_slot == fill_slot) begin
              starved = 1'b1;
            end else begin
              play_slot = (play_slot + 1) % NUM_BUF;
              remaining = slot_len[play_slot];
              play_pos = '0;
              if (remaining != 0) held_sample = pcm_mem[play_slot*BUF_LEN];
            end
          end else begin
            held_sample = pcm_mem[play_slot*BUF_LEN + play_pos];
            play_pos++;
            remaining--;
          end
          r.duty = DUTY_W'(held_sample) * DUTY_W'(gain_reg);
        end
      end
      default: ;
    endcase
    r.underrun = starved;
    if (act == ACT_ACK) starved = 1'b0;
    return r;
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // Receiver: random stalls, a long hold-off on request, none in steady stretches.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    player_result_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (due_results.size() == 0) begin
        flag_error($sformatf("unexpected result duty=%0d valid=%0b acc=%0b urun=%0b",
                             duty, duty_valid, accepted, underrun));
      end else begin
        want = due_results.pop_front();
        if (duty !== want.duty || duty_valid !== want.duty_valid ||
            accepted !== want.accepted || underrun !== want.underrun) begin
          flag_error($sformatf({"result %0d: expected duty=%0d valid=%0b acc=%0b urun=%0b,",
                                " got duty=%0d valid=%0b acc=%0b urun=%0b"},
                               n_results, want.duty, want.duty_valid, want.accepted,
                               want.underrun, duty, duty_valid, accepted, underrun));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
      $display("audio_buffer_ring_pwm_player_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input action_t act, input logic [INDEX_W-1:0] idx,
                           input logic [SAMPLE_W-1:0] val, input logic [COUNT_W-1:0] cnt);
    player_result_t r;
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    action <= act;
    sample_index <= idx;
    sample_value <= val;
    sample_count <= cnt;
    do @(posedge clk); while (in_stall);
    r = advance_player(act, idx, val, cnt);
    due_results.push_back(r);
    n_items++;
    if (r.accepted || r.duty_valid || act == ACT_ACK) n_counted++;
    if (r.duty_valid) n_ticks++;
    if ((act == ACT_WRITE || act == ACT_COMMIT) && !r.accepted) n_refused++;
  endtask

  task automatic send_simple(input action_t act);
    send_item(act, INDEX_W'($urandom_range(BUF_LEN - 1)), SAMPLE_W'($urandom()),
              COUNT_W'($urandom()));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    wait_for_results();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= g;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gain_reg = g;
    n_gains++;
  endtask

  // Fill the next buffer from index zero, commit it, then play some of it.
  task automatic play_burst();
    int len;
    logic [COUNT_W-1:0] cnt;
    while (ring_full()) send_simple(ACT_TICK);
    len = ($urandom_range(15) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
    for (int i = 0; i < len; i++) begin
      send_item(ACT_WRITE, INDEX_W'(i), SAMPLE_W'($urandom()), COUNT_W'($urandom()));
    end
    cnt = ($urandom_range(3) == 0) ? pick_count() : COUNT_W'(len);
    send_item(ACT_COMMIT, INDEX_W'($urandom()), SAMPLE_W'($urandom()), cnt);
    repeat ($urandom_range(len + 2)) send_simple(ACT_TICK);
    if ($urandom_range(9) == 0) send_simple(ACT_ACK);
  endtask

  task automatic noise_item();
    case ($urandom_range(3))
      0: send_simple(ACT_TICK);
      1: send_simple(ACT_ACK);
      2: send_item(ACT_WRITE, INDEX_W'($urandom()), SAMPLE_W'($urandom()), COUNT_W'($urandom()));
      default: begin
        send_item(ACT_COMMIT, INDEX_W'($urandom()), SAMPLE_W'($urandom()),
                  ring_full() ? COUNT_W'($urandom()) : pick_count());
      end
    endcase
  endtask

  task automatic test_idle_player();
    send_item(ACT_TICK, '0, '0, '0);
    send_item(ACT_ACK, '0, '0, '0);
    send_item(ACT_ACK, '1, '1, '1);
    send_item(ACT_TICK, '1, '1, '1);
  endtask

  // Covers playback start, underrun, an empty buffer, the repeated first sample,
  // and refusals on a full ring.
  task automatic test_ring_sequencing();
    send_item(ACT_WRITE, 11'd0, 8'd0, '0);
    send_item(ACT_WRITE, 11'd1, 8'd255, '0);
    send_item(ACT_WRITE, 11'd2047, 8'hA5, '0);
    send_item(ACT_COMMIT, '0, '0, 12'd2);
    send_item(ACT_TICK, '0, '0, '0);
    send_item(ACT_TICK, '0, '0, '0);
    send_item(ACT_TICK, '0, '0, '0);
    send_item(ACT_ACK, '0, '0, '0);
    send_item(ACT_COMMIT, '0, '0, 12'd0);
    send_item(ACT_WRITE, 11'd0, 8'd77, '0);
    send_item(ACT_COMMIT, '0, '0, 12'd1);
    send_item(ACT_COMMIT, '0, '0, 12'd0);
    send_item(ACT_COMMIT, '0, '0, 12'd4095);
    send_item(ACT_WRITE, 11'd5, 8'd1, '0);
    repeat (5) send_item(ACT_TICK, '0, '0, '0);
    send_item(ACT_ACK, '0, '0, '0);
  endtask

  task automatic test_gain_extremes();
    logic [GAIN_W-1:0] gains [3];
    gains = '{4'd15, 4'd0, 4'd1};
    foreach (gains[i]) begin
      write_gain(gains[i]);
      send_item(ACT_WRITE, 11'd0, 8'd255, '0);
      send_item(ACT_COMMIT, '0, '0, 12'd1);
      send_item(ACT_TICK, '0, '0, '0);
      send_item(ACT_TICK, '0, '0, '0);
    end
  endtask

  task automatic test_backpressure();
    write_gain(GAIN_W'($urandom_range(15, 1)));
    hold_request = 1'b1;
    repeat (6) play_burst();
    wait_for_results();
  endtask

  // An oversized count is committed and the head of that buffer is played.
  task automatic test_full_buffer();
    int target;
    while (ring_full()) send_simple(ACT_TICK);
    steady = 1'b1;
    for (int i = 0; i < FULL_PLAY; i++) begin
      send_item(ACT_WRITE, INDEX_W'(i), SAMPLE_W'($urandom()), COUNT_W'($urandom()));
    end
    send_item(ACT_WRITE, INDEX_W'(BUF_LEN - 1), SAMPLE_W'($urandom()), COUNT_W'($urandom()));
    steady = 1'b0;
    send_item(ACT_COMMIT, '1, '1, 12'd4095);
    target = fill_slot;
    while (play_slot != target) send_simple(ACT_TICK);
    repeat (FULL_PLAY) send_simple(ACT_TICK);
    send_simple(ACT_ACK);
  endtask

  task automatic test_random_traffic();
    logic [GAIN_W-1:0] phase_gain [4];
    int goal;
    phase_gain = '{GAIN_W'($urandom_range(14, 2)), 4'd15, 4'd1, GAIN_W'($urandom_range(15))};
    for (int p = 0; p < 4; p++) begin
      write_gain(phase_gain[p]);
      steady = (p == 2);
      goal = n_counted + 250;
      while (n_counted < goal) begin
        if ($urandom_range(99) < 80) play_burst();
        else noise_item();
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_idle_player();
    test_ring_sequencing();
    test_gain_extremes();
    test_backpressure();
    test_random_traffic();
    test_full_buffer();
    wait_for_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d transactions and checked %0d results under %0d gain settings.",
             n_items, n_results, n_gains);
    $display("Played %0d ticks, saw %0d refused writes or commits, %0d mismatches.",
             n_ticks, n_refused, mismatches);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("audio_buffer_ring_pwm_player_tb: PASS");
    end else begin
      $display("audio_buffer_ring_pwm_player_tb: FAIL");
    end
    $finish;
  end

endmodule
